// File: rtl/ssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  // Default sizes of the block
  localparam int LOG2_POINTS_DEF = 12;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_BITS_DEF  = 18;

  // Fixed field widths
  localparam int BIN_W          = 12;
  localparam int KERR_COEFF_W   = 32;
  localparam int DISP_COEFF_W   = 48;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 48;

  // Sign plus four integer bits ahead of the fraction
  localparam int SAMPLE_INT_BITS = 5;
  // Fraction bits of the two coefficients, in turns
  localparam int KERR_TURN_BITS  = 40;
  localparam int DISP_TURN_BITS  = 48;
  // Operand split of the wide phase products
  localparam int MUL_SPLIT       = 32;

  // Rotation unit
  localparam int ANGLE_W          = 32;
  localparam int CORDIC_W         = 32;
  localparam int CORDIC_FRAC      = 30;
  localparam int CORDIC_STEPS     = 28;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_KERR_PHASE_COEFF       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPERSION_PHASE_COEFF = 8'd1;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [ANGLE_W-1:0] atan_turn(input int i);
    case (i)
      0:       atan_turn = 32'h2000_0000;
      1:       atan_turn = 32'h12E4_051E;
      2:       atan_turn = 32'h09FB_385B;
      3:       atan_turn = 32'h0511_11D4;
      4:       atan_turn = 32'h028B_0D43;
      5:       atan_turn = 32'h0145_D7E1;
      6:       atan_turn = 32'h00A2_F61E;
      7:       atan_turn = 32'h0051_7C55;
      8:       atan_turn = 32'h0028_BE53;
      9:       atan_turn = 32'h0014_5F2F;
      10:      atan_turn = 32'h000A_2F98;
      11:      atan_turn = 32'h0005_17CC;
      12:      atan_turn = 32'h0002_8BE6;
      13:      atan_turn = 32'h0001_45F3;
      14:      atan_turn = 32'h0000_A2FA;
      15:      atan_turn = 32'h0000_517D;
      16:      atan_turn = 32'h0000_28BE;
      17:      atan_turn = 32'h0000_145F;
      18:      atan_turn = 32'h0000_0A30;
      19:      atan_turn = 32'h0000_0518;
      20:      atan_turn = 32'h0000_028C;
      21:      atan_turn = 32'h0000_0146;
      22:      atan_turn = 32'h0000_00A3;
      23:      atan_turn = 32'h0000_0051;
      24:      atan_turn = 32'h0000_0029;
      25:      atan_turn = 32'h0000_0014;
      26:      atan_turn = 32'h0000_000A;
      27:      atan_turn = 32'h0000_0005;
      default: atan_turn = 32'h0000_0000;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/ssp_phase.sv
`timescale 1ns / 1ps
`default_nettype none

module ssp_phase #(
  parameter int LOG2_POINTS = ssp_pkg::LOG2_POINTS_DEF,
  parameter int SAMPLE_BITS = ssp_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = ssp_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic signed [SAMPLE_BITS-1:0]       sample_real,
  input  logic signed [SAMPLE_BITS-1:0]       sample_imag,
  input  logic [ssp_pkg::BIN_W-1:0]           bin_index,
  input  logic [ssp_pkg::KERR_COEFF_W-1:0]    kerr_coeff,
  input  logic [ssp_pkg::DISP_COEFF_W-1:0]    disp_coeff,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       re_out,
  output logic signed [SAMPLE_BITS-1:0]       im_out,
  output logic [ssp_pkg::ANGLE_W-1:0]         theta
);

  localparam int SB    = SAMPLE_BITS;
  localparam int L     = LOG2_POINTS;
  localparam int PB    = PHASE_BITS;
  localparam int MS    = ssp_pkg::MUL_SPLIT;
  localparam int FRAC  = SB - ssp_pkg::SAMPLE_INT_BITS;
  localparam int MAG_W = 2 * SB;
  localparam int PAD_W = 2 * MS;
  localparam int MSQ_W = 2 * L - 1;
  localparam int DH_W  = ssp_pkg::DISP_COEFF_W - MS;
  localparam int DPL_W = MSQ_W + MS;
  localparam int DPH_W = MSQ_W + DH_W;
  localparam int KW    = 2 * FRAC + ssp_pkg::KERR_TURN_BITS;
  localparam int DW    = ssp_pkg::DISP_TURN_BITS;

  // Stage 1: squared magnitude and squared signed bin index
  logic [SB-1:0]        ar, ai;
  logic [MAG_W-1:0]     mag_c;
  logic [L+ssp_pkg::BIN_W-1:0] idx_ext;
  logic [L-1:0]         n, m;
  logic [MSQ_W-1:0]     msq_c;

  assign ar      = sample_real[SB-1] ? (~sample_real + 1'b1) : sample_real;
  assign ai      = sample_imag[SB-1] ? (~sample_imag + 1'b1) : sample_imag;
  assign mag_c   = ({{SB{1'b0}}, ar} * {{SB{1'b0}}, ar})
                 + ({{SB{1'b0}}, ai} * {{SB{1'b0}}, ai});
  assign idx_ext = {{L{1'b0}}, bin_index};
  assign n       = idx_ext[L-1:0];
  // Upper half of the spectrum holds negative frequencies
  assign m       = n[L-1] ? (~n + 1'b1) : n;
  assign msq_c   = MSQ_W'({{L{1'b0}}, m} * {{L{1'b0}}, m});

  logic                 v1, kind1;
  logic signed [SB-1:0] re1, im1;
  logic [MAG_W-1:0]     mag1;
  logic [MSQ_W-1:0]     msq1;

  // Stage 2: partial products of the phase
  logic [PAD_W-1:0] a_pad;
  logic [PAD_W-1:0] kp_lo_c, kp_hi_c;
  logic [DPL_W-1:0] dp_lo_c;
  logic [DPH_W-1:0] dp_hi_c;

  assign a_pad   = PAD_W'(mag1);
  assign kp_lo_c = {{MS{1'b0}}, a_pad[MS-1:0]} * {{MS{1'b0}}, kerr_coeff};
  assign kp_hi_c = {{MS{1'b0}}, a_pad[PAD_W-1:MS]} * {{MS{1'b0}}, kerr_coeff};
  assign dp_lo_c = {{MS{1'b0}}, msq1} * {{MSQ_W{1'b0}}, disp_coeff[MS-1:0]};
  assign dp_hi_c = {{DH_W{1'b0}}, msq1}
                 * {{MSQ_W{1'b0}}, disp_coeff[ssp_pkg::DISP_COEFF_W-1:MS]};

  logic                 v2, kind2;
  logic signed [SB-1:0] re2, im2;
  logic [PAD_W-1:0]     kp_lo, kp_hi;
  logic [DPL_W-1:0]     dp_lo;
  logic [DPH_W-1:0]     dp_hi;

  // Stage 3: sum the partial products and keep the turn fraction
  logic [KW-1:0]  kfull;
  logic [DW-1:0]  dfull;
  logic [PB-1:0]  kphase, dneg, phase;
  logic [ssp_pkg::ANGLE_W-1:0] theta_c;

  assign kfull   = KW'(kp_lo) + KW'({kp_hi, {MS{1'b0}}});
  assign dfull   = DW'(dp_lo) + DW'({dp_hi, {MS{1'b0}}});
  assign kphase  = kfull[KW-1 -: PB];
  // Dispersion turns the other way
  assign dneg    = ~dfull[DW-1 -: PB] + 1'b1;
  assign phase   = kind2 ? dneg : kphase;
  assign theta_c = {phase, {(ssp_pkg::ANGLE_W-PB){1'b0}}};

  logic                 v3;
  logic signed [SB-1:0] re3, im3;
  logic [ssp_pkg::ANGLE_W-1:0] theta3;

  // Each stage takes a new item when empty or when the next one moves on
  logic rdy1, rdy2, rdy3;
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1 <= kind;
      re1   <= sample_real;
      im1   <= sample_imag;
      mag1  <= mag_c;
      msq1  <= msq_c;
    end
    if (rdy2) begin
      kind2 <= kind1;
      re2   <= re1;
      im2   <= im1;
      kp_lo <= kp_lo_c;
      kp_hi <= kp_hi_c;
      dp_lo <= dp_lo_c;
      dp_hi <= dp_hi_c;
    end
    if (rdy3) begin
      re3    <= re2;
      im3    <= im2;
      theta3 <= theta_c;
    end
  end

  assign out_valid = v3;
  assign re_out    = re3;
  assign im_out    = im3;
  assign theta     = theta3;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted item missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !out_ready |=> v3 && $stable(theta3) && $stable(re3) && $stable(im3))
    else $error("stalled phase item changed");

  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && v3 && !out_ready)
    else $error("item refused with a free stage");

endmodule

`default_nettype wire

// File: rtl/ssp_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ssp_cordic_stage #(
  parameter int SAMPLE_BITS = ssp_pkg::SAMPLE_BITS_DEF,
  parameter int STAGE       = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssp_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [ssp_pkg::CORDIC_W-1:0] y_in,
  input  logic [ssp_pkg::ANGLE_W-1:0]         z_in,
  input  logic                                flip_in,
  input  logic signed [SAMPLE_BITS-1:0]       re_in,
  input  logic signed [SAMPLE_BITS-1:0]       im_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssp_pkg::CORDIC_W-1:0] x_out,
  output logic signed [ssp_pkg::CORDIC_W-1:0] y_out,
  output logic [ssp_pkg::ANGLE_W-1:0]         z_out,
  output logic                                flip_out,
  output logic signed [SAMPLE_BITS-1:0]       re_out,
  output logic signed [SAMPLE_BITS-1:0]       im_out
);

  localparam int FIRST = STAGE * ssp_pkg::CORDIC_PER_STAGE;

  logic signed [ssp_pkg::CORDIC_W-1:0] xs, ys;
  logic [ssp_pkg::ANGLE_W-1:0]         zs;

  // Micro-rotations towards zero residual angle
  always_comb begin
    logic signed [ssp_pkg::CORDIC_W-1:0] dx, dy;
    xs = x_in;
    ys = y_in;
    zs = z_in;
    for (int j = 0; j < ssp_pkg::CORDIC_PER_STAGE; j++) begin
      dx = ys >>> (FIRST + j);
      dy = xs >>> (FIRST + j);
      if (!zs[ssp_pkg::ANGLE_W-1]) begin
        xs = xs - dx;
        ys = ys + dy;
        zs = zs - ssp_pkg::atan_turn(FIRST + j);
      end else begin
        xs = xs + dx;
        ys = ys - dy;
        zs = zs + ssp_pkg::atan_turn(FIRST + j);
      end
    end
  end

  logic v;
  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x_out    <= xs;
      y_out    <= ys;
      z_out    <= zs;
      flip_out <= flip_in;
      re_out   <= re_in;
      im_out   <= im_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ssp_rotate.sv
`timescale 1ns / 1ps
`default_nettype none

module ssp_rotate #(
  parameter int SAMPLE_BITS = ssp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssp_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [ssp_pkg::CORDIC_W-1:0] y_in,
  input  logic                                flip_in,
  input  logic signed [SAMPLE_BITS-1:0]       re_in,
  input  logic signed [SAMPLE_BITS-1:0]       im_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       result_real,
  output logic signed [SAMPLE_BITS-1:0]       result_imag
);

  localparam int SB  = SAMPLE_BITS;
  localparam int P_W = SB + ssp_pkg::CORDIC_W;
  localparam int S_W = SB + ssp_pkg::CORDIC_W + 2;
  localparam logic signed [S_W-1:0] HALF =
    {{(S_W-ssp_pkg::CORDIC_FRAC){1'b0}}, 1'b1, {(ssp_pkg::CORDIC_FRAC-1){1'b0}}};
  localparam logic signed [S_W-1:0] HI = {{(S_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [S_W-1:0] LO = ~HI;

  function automatic logic signed [SB-1:0] sat(input logic signed [S_W-1:0] v);
    if (v > HI)      sat = HI[SB-1:0];
    else if (v < LO) sat = LO[SB-1:0];
    else             sat = v[SB-1:0];
  endfunction

  // Stage 1: the four products
  logic                  v1, flip1;
  logic signed [P_W-1:0] pxr, pyi, pyr, pxi;

  // Stage 2: combine, undo the half-turn fold, round and saturate
  logic signed [S_W-1:0] sr, si, sr_n, si_n, qr, qi;

  assign sr   = S_W'(pxr) - S_W'(pyi);
  assign si   = S_W'(pyr) + S_W'(pxi);
  assign sr_n = flip1 ? -sr : sr;
  assign si_n = flip1 ? -si : si;
  assign qr   = (sr_n + HALF) >>> ssp_pkg::CORDIC_FRAC;
  assign qi   = (si_n + HALF) >>> ssp_pkg::CORDIC_FRAC;

  logic v2;
  logic rdy1, rdy2;
  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      flip1 <= flip_in;
      pxr   <= re_in * x_in;
      pyi   <= im_in * y_in;
      pyr   <= re_in * y_in;
      pxi   <= im_in * x_in;
    end
    if (rdy2) begin
      result_real <= sat(qr);
      result_imag <= sat(qi);
    end
  end

endmodule

`default_nettype wire

// File: rtl/split_step_phase_rotator.sv
// Split-step phase rotator: each input item is a complex sample in signed Q4.(SAMPLE_BITS-5)
// and is rotated by the Kerr phase (kind 0, proportional to its squared magnitude) or by
// minus the dispersion phase (kind 1, proportional to the squared signed frequency of
// bin_index, wrapped to 2^LOG2_POINTS bins). The pipeline takes one item per cycle while
// the output is not stalled. The phase stages form the phase (squares, split wide products,
// final sum), the CORDIC stages run the 28 micro-rotations four at a time, and the rotate
// stages multiply the sample by cos/sin and round and saturate. Each stage holds one item and
// moves it on when the next stage is free, so a stalled output only blocks entry once every
// stage is full. Configuration writes are always ready and take effect at once;
// write them only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module split_step_phase_rotator #(
  parameter int LOG2_POINTS = ssp_pkg::LOG2_POINTS_DEF,
  parameter int SAMPLE_BITS = ssp_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = ssp_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [SAMPLE_BITS-1:0]     sample_real,
  input  logic signed [SAMPLE_BITS-1:0]     sample_imag,
  input  logic [ssp_pkg::BIN_W-1:0]         bin_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     result_real,
  output logic signed [SAMPLE_BITS-1:0]     result_imag
);

  localparam int NST = ssp_pkg::CORDIC_STAGES;
  localparam int AW  = ssp_pkg::ANGLE_W;

  logic [ssp_pkg::KERR_COEFF_W-1:0] kerr_phase_coeff;
  logic [ssp_pkg::DISP_COEFF_W-1:0] dispersion_phase_coeff;

  assign cfg_ready = 1'b1;

  // Unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      kerr_phase_coeff       <= '0;
      dispersion_phase_coeff <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssp_pkg::REG_KERR_PHASE_COEFF:
          kerr_phase_coeff <= cfg_data[ssp_pkg::KERR_COEFF_W-1:0];
        ssp_pkg::REG_DISPERSION_PHASE_COEFF:
          dispersion_phase_coeff <= cfg_data[ssp_pkg::DISP_COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  logic                          ph_valid;
  logic signed [SAMPLE_BITS-1:0] ph_re, ph_im;
  logic [AW-1:0]                 ph_theta;

  logic                                cv    [NST+1];
  logic                                crdy  [NST+1];
  logic signed [ssp_pkg::CORDIC_W-1:0] cx    [NST+1];
  logic signed [ssp_pkg::CORDIC_W-1:0] cy    [NST+1];
  logic [AW-1:0]                       cz    [NST];
  logic                                cflip [NST+1];
  logic signed [SAMPLE_BITS-1:0]       cre   [NST+1];
  logic signed [SAMPLE_BITS-1:0]       cim   [NST+1];
  logic [AW-1:0]                       z_last;

  ssp_phase #(
    .LOG2_POINTS (LOG2_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .sample_real (sample_real),
    .sample_imag (sample_imag),
    .bin_index   (bin_index),
    .kerr_coeff  (kerr_phase_coeff),
    .disp_coeff  (dispersion_phase_coeff),
    .out_valid   (ph_valid),
    .out_ready   (crdy[0]),
    .re_out      (ph_re),
    .im_out      (ph_im),
    .theta       (ph_theta)
  );

  // Fold the angle into the right half-plane; the sign comes back at the end
  assign cv[0]    = ph_valid;
  assign cx[0]    = ssp_pkg::CORDIC_INV_GAIN;
  assign cy[0]    = '0;
  assign cflip[0] = ph_theta[AW-1] ^ ph_theta[AW-2];
  assign cz[0]    = {ph_theta[AW-1] ^ cflip[0], ph_theta[AW-2:0]};
  assign cre[0]   = ph_re;
  assign cim[0]   = ph_im;

  for (genvar s = 0; s < NST; s++) begin : g_cordic
    if (s < NST - 1) begin : g_mid
      ssp_cordic_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STAGE       (s)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (cv[s]),
        .in_ready  (crdy[s]),
        .x_in      (cx[s]),
        .y_in      (cy[s]),
        .z_in      (cz[s]),
        .flip_in   (cflip[s]),
        .re_in     (cre[s]),
        .im_in     (cim[s]),
        .out_valid (cv[s+1]),
        .out_ready (crdy[s+1]),
        .x_out     (cx[s+1]),
        .y_out     (cy[s+1]),
        .z_out     (cz[s+1]),
        .flip_out  (cflip[s+1]),
        .re_out    (cre[s+1]),
        .im_out    (cim[s+1])
      );
    end else begin : g_last
      ssp_cordic_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STAGE       (s)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (cv[s]),
        .in_ready  (crdy[s]),
        .x_in      (cx[s]),
        .y_in      (cy[s]),
        .z_in      (cz[s]),
        .flip_in   (cflip[s]),
        .re_in     (cre[s]),
        .im_in     (cim[s]),
        .out_valid (cv[s+1]),
        .out_ready (crdy[s+1]),
        .x_out     (cx[s+1]),
        .y_out     (cy[s+1]),
        .z_out     (z_last),
        .flip_out  (cflip[s+1]),
        .re_out    (cre[s+1]),
        .im_out    (cim[s+1])
      );
    end
  end

  ssp_rotate #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rotate (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cv[NST]),
    .in_ready    (crdy[NST]),
    .x_in        (cx[NST]),
    .y_in        (cy[NST]),
    .flip_in     (cflip[NST]),
    .re_in       (cre[NST]),
    .im_in       (cim[NST]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_real (result_real),
    .result_imag (result_imag)
  );

  // Residual angle after the last micro-rotation stays within 2^-16 turns of zero
  a_residual_small: assert property (@(posedge clk) disable iff (rst)
    cv[NST] |-> (z_last[AW-1:16] == '0) || (z_last[AW-1:16] == '1))
    else $error("rotation residual far from zero");

  a_refuse_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("item refused while output drains");

endmodule

`default_nettype wire
